FILE: hw/rtl/gn2d_pkg.sv
// ---------------------------------------------------------------------------
// gn2d_pkg: shared constants for the 2D gradient noise core
// Fixed-point formats, hash constants and derived widths.
// ---------------------------------------------------------------------------
package gn2d_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int OUT_BITS        = 16;

    localparam int COORD_W = 32;
    // Cell coordinate width, with room for the cell plus one.
    localparam int CELL_W  = COORD_W - COORD_FRAC_BITS + 1;
    localparam int GX_W    = 17;
    localparam int W_W     = COORD_FRAC_BITS + 1;
    localparam int NW      = COORD_FRAC_BITS + 4;

    localparam logic [31:0] SEED_RESET = 32'd1791095845;
    localparam logic [31:0] SO_RESET   = (SEED_RESET << 7) + (SEED_RESET >> 3);
    localparam logic [31:0] HASH_MASK  = 32'hfffffff8;
    localparam logic [30:0] SQRT2_Q30  = 31'd1518500250;

    localparam int SQ_N = 17;
    localparam int SQ_W = 34;

    typedef struct packed {
        logic [3:0][GX_W-1:0]        gx;
        logic [COORD_FRAC_BITS-1:0]  dx;
        logic [COORD_FRAC_BITS-1:0]  dy;
        logic [W_W-1:0]              wx;
        logic [W_W-1:0]              wy;
    } side_t;

endpackage

FILE: hw/rtl/gradient_noise_2d_core.sv
// ---------------------------------------------------------------------------
// gradient_noise_2d_core: pipelined 2D gradient noise
// Maps a signed Q16.16 point to a noise value in unsigned Q0.16.
// ---------------------------------------------------------------------------
//
//  channel   signals                                  direction
//  point     point_valid, point_stall, point_x/y      in (word = one point)
//  noise     noise_valid, noise_stall, noise_value    out (word = one sample)
//  config    cfg_valid, cfg_ready, seed_offset        in (word = seed offset)
//
// A new point is taken every cycle unless the output is stalled; each one
// passes through 31 register stages before its noise word is offered. 17 of the
// stages are the bit-per-stage square root that forms the gradient's y part.
// All stages advance together, and they hold when the output word is stalled.
// Reset (rst_n, asynchronous) clears all valid bits and loads the default seed.
// A seed write passes through seed_reg and then so_reg before the hash uses it.
module gradient_noise_2d_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    point_valid,
    output logic                                    point_stall,
    input  logic signed [gn2d_pkg::COORD_W-1:0]     point_x,
    input  logic signed [gn2d_pkg::COORD_W-1:0]     point_y,
    output logic                                    noise_valid,
    input  logic                                    noise_stall,
    output logic [gn2d_pkg::OUT_BITS-1:0]           noise_value,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [31:0]                             seed_offset
);
    import gn2d_pkg::*;

    localparam int F     = COORD_FRAC_BITS;
    localparam int NST   = 14 + SQ_N;
    localparam int S_SQ  = 6;
    localparam int S_MUL = S_SQ + SQ_N;
    localparam int PW    = GX_W + F + 3;
    localparam int LPW   = W_W + 1 + NW + 1;
    localparam int FPW   = NW + 32;
    localparam int QSH   = F + 30 - OUT_BITS;

    // Float pattern of a small integer cell coordinate, masked for the hash.
    function automatic logic [31:0] float_bits(input logic signed [CELL_W-1:0] n);
        logic [CELL_W-1:0] mag;
        logic [4:0]        e;
        logic [46:0]       wide;
        logic [31:0]       res;
        mag = n[CELL_W-1] ? CELL_W'(-n) : CELL_W'(n);
        e = 5'd0;
        for (int i = 0; i < CELL_W; i++)
        begin
            if (mag[i])
            begin
                e = 5'(i);
            end
        end
        wide = 47'(mag) << (5'd23 - e);
        if (n == '0)
        begin
            res = 32'd0;
        end
        else
        begin
            res = {n[CELL_W-1], 8'(8'd127 + 8'(e)), wide[22:0]};
        end
        return res & HASH_MASK;
    endfunction

    function automatic logic [31:0] xorshift(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 7);
        t = t ^ (t << 17);
        return t;
    endfunction

    // Control.
    logic [NST-1:0] vld_reg;
    logic           adv;
    logic           accept;
    logic [31:0]    seed_reg;
    logic [31:0]    so_reg;

    assign adv         = !vld_reg[NST-1] || !noise_stall;
    assign point_stall = !adv;
    assign accept      = point_valid && adv;
    assign cfg_ready   = 1'b1;
    assign noise_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            seed_reg <= SEED_RESET;
            so_reg   <= SO_RESET;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= {vld_reg[NST-2:0], accept};
            end
            if (cfg_valid && cfg_ready)
            begin
                seed_reg <= seed_offset;
            end
            so_reg <= (seed_reg << 7) + (seed_reg >> 3);
        end
    end

    // Stage 1: input word.
    logic signed [COORD_W-1:0] px_reg, py_reg;
    // Stage 2: cell corners and fractions.
    logic signed [CELL_W-1:0]  cx0_reg, cx1_reg, cy0_reg, cy1_reg;
    logic [F-1:0]              dx2_reg, dy2_reg;
    // Stage 3: float patterns and squared fractions.
    logic [31:0]               hx0_reg, hx1_reg, hy0_reg, hy1_reg;
    logic [F-1:0]              d2x_reg, d2y_reg, dx3_reg, dy3_reg;
    // Stage 4: hash inputs and weights.
    logic [3:0][31:0]          pre_reg;
    logic [W_W-1:0]            wx4_reg, wy4_reg;
    logic [F-1:0]              dx4_reg, dy4_reg;
    // Stage 5: gradient x parts.
    side_t                     sd5_reg;
    // Stage 6: squares of the gradient x parts.
    side_t                     sd6_reg;
    logic [3:0][SQ_W-1:0]      gxsq_reg;

    logic signed [CELL_W-1:0]  cx_next, cy_next;
    logic [3:0][31:0]          pre_next;
    logic [3:0][31:0]          hy_sel, hx_sel;
    side_t                     sd5_next;
    logic [31:0]               hash_tmp;

    always_comb
    begin
        cx_next = CELL_W'(px_reg >>> F);
        cy_next = CELL_W'(py_reg >>> F);
    end

    // Corner order: 00, 10, 01, 11.
    assign hx_sel = {hx1_reg, hx0_reg, hx1_reg, hx0_reg};
    assign hy_sel = {hy1_reg, hy1_reg, hy0_reg, hy0_reg};

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            pre_next[c] = ~(hx_sel[c] ^ ((hy_sel[c] << 6) + 32'($signed(hy_sel[c]) >>> 2)))
                          + so_reg;
        end
    end

    always_comb
    begin
        sd5_next.dx = dx4_reg;
        sd5_next.dy = dy4_reg;
        sd5_next.wx = wx4_reg;
        sd5_next.wy = wy4_reg;
        for (int c = 0; c < 4; c++)
        begin
            hash_tmp = xorshift(pre_reg[c]);
            sd5_next.gx[c] = GX_W'(({1'b0, hash_tmp} + 33'h8000) >> 16);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg   <= point_x;
            py_reg   <= point_y;
            cx0_reg  <= cx_next;
            cx1_reg  <= cx_next + CELL_W'(1);
            cy0_reg  <= cy_next;
            cy1_reg  <= cy_next + CELL_W'(1);
            dx2_reg  <= px_reg[F-1:0];
            dy2_reg  <= py_reg[F-1:0];
            hx0_reg  <= float_bits(cx0_reg);
            hx1_reg  <= float_bits(cx1_reg);
            hy0_reg  <= float_bits(cy0_reg);
            hy1_reg  <= float_bits(cy1_reg);
            d2x_reg  <= F'(({F'(0), dx2_reg} * {F'(0), dx2_reg}) >> F);
            d2y_reg  <= F'(({F'(0), dy2_reg} * {F'(0), dy2_reg}) >> F);
            dx3_reg  <= dx2_reg;
            dy3_reg  <= dy2_reg;
            pre_reg  <= pre_next;
            wx4_reg  <= W_W'(({(F+2)'(0), d2x_reg} *
                        (((F+2)'(3) << F) - {1'b0, dx3_reg, 1'b0})) >> F);
            wy4_reg  <= W_W'(({(F+2)'(0), d2y_reg} *
                        (((F+2)'(3) << F) - {1'b0, dy3_reg, 1'b0})) >> F);
            dx4_reg  <= dx3_reg;
            dy4_reg  <= dy3_reg;
            sd5_reg  <= sd5_next;
            sd6_reg  <= sd5_reg;
            for (int c = 0; c < 4; c++)
            begin
                gxsq_reg[c] <= SQ_W'(sd5_reg.gx[c]) * SQ_W'(sd5_reg.gx[c]);
            end
        end
    end

    // Square root of 2^32 - gx^2, one result bit per stage.
    logic [3:0][SQ_W-1:0] sqv_reg [SQ_N];
    logic [3:0][SQ_W-1:0] sqr_reg [SQ_N];
    side_t                sqs_reg [SQ_N];

    for (genvar k = 0; k < SQ_N; k++)
    begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_N - 1 - k));
        logic [3:0][SQ_W-1:0] v_in, r_in, v_out, r_out;
        side_t                s_in;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                for (int c = 0; c < 4; c++)
                begin
                    v_in[c] = (SQ_W'(1) << 32) - gxsq_reg[c];
                    r_in[c] = '0;
                end
                s_in = sd6_reg;
            end
        end
        else
        begin : g_rest
            assign v_in = sqv_reg[k-1];
            assign r_in = sqr_reg[k-1];
            assign s_in = sqs_reg[k-1];
        end

        always_comb
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (v_in[c] >= r_in[c] + BIT)
                begin
                    v_out[c] = v_in[c] - (r_in[c] + BIT);
                    r_out[c] = (r_in[c] >> 1) + BIT;
                end
                else
                begin
                    v_out[c] = v_in[c];
                    r_out[c] = r_in[c] >> 1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sqv_reg[k] <= v_out;
                sqr_reg[k] <= r_out;
                sqs_reg[k] <= s_in;
            end
        end
    end

    // Dot products, bilinear blend and final scaling.
    side_t                       sl;
    logic signed [3:0][F+1:0]    dxs, dys;
    logic signed [3:0][PW-1:0]   pgx_reg, pgy_reg;
    logic [W_W-1:0]              wx7_reg, wx8_reg, wy7_reg, wy8_reg, wy9_reg, wy10_reg;
    logic signed [3:0][NW-1:0]   n_reg;
    logic signed [NW-1:0]        n00_9_reg, n01_9_reg;
    logic signed [LPW-1:0]       lx0_reg, lx1_reg, ly_reg;
    logic signed [NW-1:0]        a0_reg, a1_reg, a0_11_reg, r_reg;
    logic signed [FPW-1:0]       vp_reg;
    logic signed [FPW:0]         v_fin;
    logic signed [FPW:0]         q_fin;
    logic [OUT_BITS-1:0]         noise_value_reg;
    logic [OUT_BITS-1:0]         noise_value_next;

    assign sl = sqs_reg[SQ_N-1];

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            dxs[c] = (c == 1 || c == 3) ? $signed({2'b00, sl.dx}) - $signed((F+2)'(1) << F)
                                        : $signed({2'b00, sl.dx});
            dys[c] = (c == 2 || c == 3) ? $signed({2'b00, sl.dy}) - $signed((F+2)'(1) << F)
                                        : $signed({2'b00, sl.dy});
        end
    end

    always_comb
    begin
        v_fin = FPW'(vp_reg) + $signed((FPW+1)'(1) << (F + 29));
        q_fin = v_fin >>> QSH;
        if (v_fin < 0)
        begin
            noise_value_next = '0;
        end
        else if (q_fin > $signed((FPW+1)'((1 << OUT_BITS) - 1)))
        begin
            noise_value_next = '1;
        end
        else
        begin
            noise_value_next = q_fin[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 4; c++)
            begin
                pgx_reg[c] <= $signed(PW'({1'b0, sl.gx[c]})) * PW'($signed(dxs[c]));
                pgy_reg[c] <= $signed(PW'({1'b0, sqr_reg[SQ_N-1][c][GX_W-1:0]})) *
                              PW'($signed(dys[c]));
                n_reg[c]   <= NW'(($signed({pgx_reg[c][PW-1], pgx_reg[c]}) +
                                   $signed({pgy_reg[c][PW-1], pgy_reg[c]})) >>> 16);
            end
            wx7_reg   <= sl.wx;
            wx8_reg   <= wx7_reg;
            wy7_reg   <= sl.wy;
            wy8_reg   <= wy7_reg;
            lx0_reg   <= $signed(LPW'({1'b0, wx8_reg})) *
                         LPW'($signed(n_reg[1]) - $signed(n_reg[0]));
            lx1_reg   <= $signed(LPW'({1'b0, wx8_reg})) *
                         LPW'($signed(n_reg[3]) - $signed(n_reg[2]));
            n00_9_reg <= n_reg[0];
            n01_9_reg <= n_reg[2];
            wy9_reg   <= wy8_reg;
            a0_reg    <= n00_9_reg + NW'(lx0_reg >>> F);
            a1_reg    <= n01_9_reg + NW'(lx1_reg >>> F);
            wy10_reg  <= wy9_reg;
            ly_reg    <= $signed(LPW'({1'b0, wy10_reg})) * LPW'(a1_reg - a0_reg);
            a0_11_reg <= a0_reg;
            r_reg     <= a0_11_reg + NW'(ly_reg >>> F);
            vp_reg    <= FPW'(r_reg) * $signed(FPW'({1'b0, SQRT2_Q30}));
            noise_value_reg <= noise_value_next;
        end
    end

    assign noise_value = noise_value_reg;

`ifndef SYNTHESIS
    // The input is held back exactly when a finished word waits on a stall.
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        point_stall == (noise_valid && noise_stall))
        else $error("point_stall does not follow the output stall");

    // An accepted point occupies the first stage on the next edge.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && !point_stall) |=> vld_reg[0])
        else $error("accepted point lost at pipeline entry");

    // A stalled output word stays valid.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (noise_valid && noise_stall) |=> (noise_valid && $stable(noise_value_reg)))
        else $error("stalled output word changed");
`endif

endmodule

FILE: dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench for the 2D gradient noise core
// Streams points through the core under random idling and stalls, predicts
// each noise word in the bench and checks it, and changes the seed between
// phases of the run.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gn2d_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS = 390;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic point_valid = 1'b0;
    logic point_stall;
    logic signed [COORD_W-1:0] point_x = '0;
    logic signed [COORD_W-1:0] point_y = '0;
    logic noise_valid;
    logic noise_stall = 1'b0;
    logic [OUT_BITS-1:0] noise_value;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [31:0] seed_offset = '0;

    point_t pending_points[$];
    logic [OUT_BITS-1:0] expected_noise[$];
    logic [31:0] model_seed = SEED_RESET;
    int errors = 0;
    int points_sent = 0;
    int words_seen = 0;
    int seeds_written = 0;
    int send_gap = 0;
    int recv_gap = 0;
    logic send_burst = 1'b0;
    logic recv_burst = 1'b0;
    logic hold_output = 1'b0;
    int idle_cycles = 0;

    gradient_noise_2d_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point_x     (point_x),
        .point_y     (point_y),
        .noise_valid (noise_valid),
        .noise_stall (noise_stall),
        .noise_value (noise_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .seed_offset (seed_offset)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Noise predictor. Coordinate and blend arithmetic is done in 64-bit
    // integers, wide enough not to overflow; the hash wraps in 32 bits.
    // ------------------------------------------------------------------

    // Single-precision bit pattern of a small integer (always exact here).
    function automatic logic [31:0] float_pattern(longint n);
        logic [31:0] sgn;
        longint mag;
        longint mant;
        int e;
        if (n == 0)
            return 32'd0;
        sgn = (n < 0) ? 32'h8000_0000 : 32'd0;
        mag = (n < 0) ? -n : n;
        e = 0;
        while (e < 62 && (mag >> (e + 1)) != 0)
            e++;
        mant = (e <= 23) ? (mag << (23 - e)) : (mag >> (e - 23));
        return sgn | (32'(127 + e) << 23) | (32'(mant) & 32'h007f_ffff);
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(root);
    endfunction

    // Gradient of one corner dotted with the offset from it, in Q.F.
    function automatic longint corner_dot(longint cx, longint cy, longint dx, longint dy,
                                          logic [31:0] seed);
        logic [31:0] hx;
        logic [31:0] ys;
        logic [31:0] ysr;
        logic [31:0] mix;
        logic [31:0] so;
        logic [31:0] h;
        longint gx;
        longint gy;
        hx = float_pattern(cx) & HASH_MASK;
        ys = float_pattern(cy) & HASH_MASK;
        // The y term shifts right arithmetically, keeping the sign bit.
        ysr = 32'($signed(ys) >>> 2);
        mix = (ys << 6) + ysr;
        so = (seed << 7) + (seed >> 3);
        h = ~(hx ^ mix) + so;
        h ^= h << 13;
        h ^= h >> 7;
        h ^= h << 17;
        gx = (longint'(h) + 64'h8000) >> 16;
        gy = int_sqrt(64'(64'd1 << 32) - 64'(gx * gx));
        return (gx * dx + gy * dy) >>> 16;
    endfunction

    function automatic longint smoothstep_weight(longint d);
        longint d2;
        longint k;
        d2 = (d * d) >> COORD_FRAC_BITS;
        k = (longint'(3) << COORD_FRAC_BITS) - 2 * d;
        return (d2 * k) >> COORD_FRAC_BITS;
    endfunction

    function automatic longint blend(longint a, longint b, longint w);
        return a + ((w * (b - a)) >>> COORD_FRAC_BITS);
    endfunction

    function automatic logic [OUT_BITS-1:0] noise_sample(point_t p, logic [31:0] seed);
        longint one;
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        longint wx;
        longint wy;
        longint r;
        longint v;
        longint q;
        one = longint'(1) << COORD_FRAC_BITS;
        cx = longint'(p.x) >>> COORD_FRAC_BITS;
        cy = longint'(p.y) >>> COORD_FRAC_BITS;
        dx = longint'(p.x) & (one - 1);
        dy = longint'(p.y) & (one - 1);
        wx = smoothstep_weight(dx);
        wy = smoothstep_weight(dy);
        r = blend(blend(corner_dot(cx, cy, dx, dy, seed),
                        corner_dot(cx + 1, cy, dx - one, dy, seed), wx),
                  blend(corner_dot(cx, cy + 1, dx, dy - one, seed),
                        corner_dot(cx + 1, cy + 1, dx - one, dy - one, seed), wx), wy);
        v = r * longint'(SQRT2_Q30) + (longint'(1) << (COORD_FRAC_BITS + 29));
        // Below zero clamps to zero, one or more clamps to the largest code.
        if (v < 0)
            return '0;
        q = v >> (COORD_FRAC_BITS + 30 - OUT_BITS);
        if (q > (longint'(1) << OUT_BITS) - 1)
            q = (longint'(1) << OUT_BITS) - 1;
        return OUT_BITS'(q);
    endfunction

    // ------------------------------------------------------------------
    // Point driver. A word on offer stays put until it is accepted; only
    // then does the driver wait out its gap and offer the next one. Each
    // branch makes exactly one assignment to point_valid.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (point_valid && point_stall) begin
                point_valid <= 1'b1;
            end
            else begin
                if (point_valid) begin
                    expected_noise.push_back(noise_sample('{point_x, point_y}, model_seed));
                    points_sent++;
                end
                if (send_gap > 0) begin
                    send_gap--;
                    point_valid <= 1'b0;
                end
                else if (pending_points.size() > 0) begin
                    point_x <= pending_points[0].x;
                    point_y <= pending_points[0].y;
                    void'(pending_points.pop_front());
                    point_valid <= 1'b1;
                    if ($urandom_range(0, 63) == 0)
                        send_burst = ~send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 15);
                end
                else begin
                    point_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Noise monitor. Checks each accepted word against the oldest
    // prediction, then draws how long to stall before the next word.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (noise_valid && !noise_stall) begin
                words_seen++;
                if (expected_noise.size() == 0) begin
                    $display("%0t: noise word with none expected: expected none, actual %0h",
                             $time, noise_value);
                    errors++;
                end
                else begin
                    if (noise_value !== expected_noise[0]) begin
                        $display("%0t: noise_value mismatch: expected %0h, actual %0h",
                                 $time, expected_noise[0], noise_value);
                        errors++;
                    end
                    void'(expected_noise.pop_front());
                end
                if ($urandom_range(0, 63) == 0)
                    recv_burst = ~recv_burst;
                recv_gap = recv_burst ? 0 : $urandom_range(0, 15);
            end
            else if (recv_gap > 0) begin
                recv_gap--;
            end
            noise_stall <= hold_output || (recv_gap != 0);
        end
    end

    // Long output hold so the pipeline fills and pushes back on the input.
    initial begin
        wait (points_sent >= 500);
        @(posedge clk);
        hold_output <= 1'b1;
        repeat (250) @(posedge clk);
        hold_output <= 1'b0;
    end

    // Watchdog: nothing accepted on either channel for too long.
    always @(posedge clk) begin
        if ((point_valid && !point_stall) || (noise_valid && !noise_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // Waits until every point is sent and every noise word has come back.
    task automatic wait_drained();
        while (pending_points.size() > 0 || point_valid || expected_noise.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(logic [31:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        seed_offset <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        model_seed = value;
        seeds_written++;
        cfg_valid <= 1'b0;
        repeat (4) @(posedge clk);
    endtask

    task automatic add_point(logic [31:0] x, logic [31:0] y);
        pending_points.push_back('{x, y});
    endtask

    // Half the coordinates lie in cells -4 to 4, where corners repeat and
    // the zero pattern shows up; a quarter are extremes, a quarter random.
    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return {$urandom_range(0, 1) ? 16'h8000 : 16'h7fff,
                             16'($urandom())};
            default: return {16'(int'($urandom_range(0, 8)) - 4), 16'($urandom())};
        endcase
    endfunction

    initial begin
        logic [31:0] phase_seeds[5];
        phase_seeds = '{SEED_RESET, 32'd0, 32'hffff_ffff, $urandom(), $urandom()};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points: coordinate extremes, the zero cell and its
        // neighbors, and the largest fraction on each axis.
        add_point(32'h0000_0000, 32'h0000_0000);
        add_point(32'h7fff_ffff, 32'h7fff_ffff);
        add_point(32'h8000_0000, 32'h8000_0000);
        add_point(32'h8000_0000, 32'h7fff_ffff);
        add_point(32'h7fff_ffff, 32'h8000_0000);
        add_point(32'hffff_ffff, 32'hffff_ffff);
        add_point(32'hffff_0000, 32'h0000_ffff);
        add_point(32'h0000_8000, 32'h0000_8000);
        add_point(32'hffff_8000, 32'h0001_8000);
        add_point(32'h0001_0000, 32'hffff_0000);
        add_point(32'h0000_0001, 32'h8000_0001);
        add_point(32'h7fff_0000, 32'h0000_0000);
        add_point(32'h0000_4000, 32'hffff_c000);
        add_point(32'h1234_5678, 32'hedcb_a987);
        add_point(32'haaaa_aaaa, 32'h5555_5555);
        add_point(32'h5555_5555, 32'haaaa_aaaa);

        foreach (phase_seeds[i]) begin
            write_seed(phase_seeds[i]);
            repeat (PHASE_ITEMS)
                add_point(random_coord(), random_coord());
        end
        wait_drained();

        $display("Sent %0d points and checked %0d noise words under %0d seed settings,",
                 points_sent, words_seen, seeds_written);
        $display("with random gaps, stalls and one long output hold.");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
